// ===== src/nearest_neighbor_tour_macros.svh =====
// Assertion macros for the nearest-neighbor tour block.
`ifndef NEAREST_NEIGHBOR_TOUR_MACROS_SVH
`define NEAREST_NEIGHBOR_TOUR_MACROS_SVH
`ifndef ASSERT_OFF
`define NNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NNT_ASSERT(label, prop, msg)
`define NNT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/nnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nnt_pkg;
  localparam int unsigned MAX_CITIES = 1024;
  localparam int unsigned COORD_BITS = 16;

  localparam int unsigned IDX_W  = $clog2(MAX_CITIES);
  localparam int unsigned CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int unsigned CITY_W = 10;
  localparam int unsigned LEN_W  = 27;
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned ROOT_W = DIFF_W + 1;
  localparam int unsigned S_W    = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned D_W    = ROOT_W + 1;
  localparam int unsigned WORD_W = 2 * COORD_BITS + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_DONE  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } in_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [LEN_W-1:0]  running_length;
    logic              last_city;
    status_e           status;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             skip;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic [S_W-1:0]    s;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cell_t;

  function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [D_W-1:0] b);
    logic [LEN_W:0] sum;
    sum = {1'b0, a} + (LEN_W + 1)'(b);
    return sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== src/nnt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/nnt_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nnt_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nnt_pkg::cell_t cell_i,
  output nnt_pkg::cell_t     cell_o
);
  logic [nnt_pkg::REM_W+1:0] trial;
  logic [nnt_pkg::REM_W+1:0] sub;
  nnt_pkg::cell_t            cell_d;
  nnt_pkg::cell_t            cell_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.s[nnt_pkg::S_W-1 -: 2]};
    sub   = (nnt_pkg::REM_W + 2)'({cell_i.root, 2'b01});
    cell_d       = cell_i;
    cell_d.s     = cell_i.s << 2;
    if (trial >= sub) begin
      cell_d.rem  = nnt_pkg::REM_W'(trial - sub);
      cell_d.root = {cell_i.root[nnt_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      cell_d.rem  = trial[nnt_pkg::REM_W-1:0];
      cell_d.root = {cell_i.root[nnt_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule
`default_nettype wire

// ===== src/nnt_dist_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nnt_dist_pipe (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire nnt_pkg::tag_t           in_tag_i,
  input  wire nnt_pkg::coord_t         ax_i,
  input  wire nnt_pkg::coord_t         ay_i,
  input  wire nnt_pkg::coord_t         bx_i,
  input  wire nnt_pkg::coord_t         by_i,
  output logic                         out_valid_o,
  output nnt_pkg::tag_t                out_tag_o,
  output logic [nnt_pkg::D_W-1:0]      out_dist_o
);
  logic signed [nnt_pkg::DIFF_W-1:0] dx, dy;
  logic [nnt_pkg::DIFF_W-1:0]        adx, ady;
  logic [nnt_pkg::DIFF_W-1:0]        adx_q, ady_q;
  logic                              v1_q, v2_q, vo_q;
  nnt_pkg::tag_t                     tag1_q, tag2_q, tago_q;
  logic [nnt_pkg::SQ_W-1:0]          sqx_q, sqy_q;
  nnt_pkg::cell_t                    c0_q;
  nnt_pkg::cell_t                    chain [nnt_pkg::ROOT_W+1];
  nnt_pkg::cell_t                    fin;
  logic [nnt_pkg::D_W-1:0]           dist_q;

  always_comb begin
    dx  = nnt_pkg::DIFF_W'(ax_i) - nnt_pkg::DIFF_W'(bx_i);
    dy  = nnt_pkg::DIFF_W'(ay_i) - nnt_pkg::DIFF_W'(by_i);
    adx = dx[nnt_pkg::DIFF_W-1] ? nnt_pkg::DIFF_W'(-dx) : nnt_pkg::DIFF_W'(dx);
    ady = dy[nnt_pkg::DIFF_W-1] ? nnt_pkg::DIFF_W'(-dy) : nnt_pkg::DIFF_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
      c0_q <= '0;
    end else begin
      v1_q       <= in_valid_i;
      v2_q       <= v1_q;
      c0_q.valid <= v2_q;
      c0_q.tag   <= tag2_q;
      c0_q.s     <= nnt_pkg::S_W'(sqx_q) + nnt_pkg::S_W'(sqy_q);
      c0_q.rem   <= '0;
      c0_q.root  <= '0;
      vo_q       <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= in_tag_i;
    adx_q  <= adx;
    ady_q  <= ady;
    tag2_q <= tag1_q;
    sqx_q  <= nnt_pkg::SQ_W'(adx_q) * nnt_pkg::SQ_W'(adx_q);
    sqy_q  <= nnt_pkg::SQ_W'(ady_q) * nnt_pkg::SQ_W'(ady_q);
    tago_q <= fin.tag;
    dist_q <= nnt_pkg::D_W'(fin.root)
            + nnt_pkg::D_W'(fin.rem > nnt_pkg::REM_W'(fin.root));
  end

  assign chain[0] = c0_q;

  for (genvar g = 0; g < nnt_pkg::ROOT_W; g++) begin : g_cell
    nnt_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign fin         = chain[nnt_pkg::ROOT_W];
  assign out_valid_o = vo_q;
  assign out_tag_o   = tago_q;
  assign out_dist_o  = dist_q;
endmodule
`default_nettype wire

// ===== src/nearest_neighbor_tour.sv =====
// Channel | Direction | Signals                         | Payload
// input   | in        | in_valid_i / in_ready_o         | nnt_pkg::in_t  in_data_i
// output  | out       | out_valid_o / out_ready_i       | nnt_pkg::out_t out_data_o
//
// Load and clear complete in the idle state. An advance scans all stored cities through the
// distance pipe (three front stages, one square-root cell per root bit, a rounding
// stage), then latches the nearest unplaced city; the final city also sends
// its closing edge to the first city through the pipe. The first city skips the scan.
// Reset clears counts and length; the coordinate store needs no clearing.
// A finished result waits in the output register; a new one waits for it to drain.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_tour_macros.svh"
module nearest_neighbor_tour (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire nnt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output nnt_pkg::out_t      out_data_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_FETCH, S_LATCH, S_CLOSE, S_CWAIT, S_EMIT
  } state_e;

  localparam int unsigned C = nnt_pkg::COORD_BITS;

  state_e                       state_q;
  logic [nnt_pkg::CNT_W-1:0]    cnt_q, placed_q;
  logic [nnt_pkg::IDX_W-1:0]    cur_q, j_q, best_q, rd_idx_q;
  logic [nnt_pkg::LEN_W-1:0]    len_q, len_n;
  logic [nnt_pkg::D_W-1:0]      best_d_q, nbest_d;
  logic                         found_q, rd_v_q, rd_last_q;
  nnt_pkg::coord_t              curx_q, cury_q, x0_q, y0_q;
  nnt_pkg::out_t                res_q, out_q;
  logic                         out_valid_q;

  logic                         we;
  logic [nnt_pkg::IDX_W-1:0]    waddr, raddr;
  logic [nnt_pkg::WORD_W-1:0]   wdata, rdata;
  logic                         out_load, take, scan_end;
  logic [nnt_pkg::IDX_W-1:0]    nbest;

  logic                         pv, pipe_v;
  nnt_pkg::tag_t                ptag_in, ptag;
  nnt_pkg::coord_t              bx, by;
  logic [nnt_pkg::D_W-1:0]      pd;

  nnt_ram #(.WIDTH(nnt_pkg::WORD_W), .DEPTH(nnt_pkg::MAX_CITIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nnt_dist_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pv),
    .in_tag_i    (ptag_in),
    .ax_i        (curx_q),
    .ay_i        (cury_q),
    .bx_i        (bx),
    .by_i        (by),
    .out_valid_o (pipe_v),
    .out_tag_o   (ptag),
    .out_dist_o  (pd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[nnt_pkg::IDX_W-1:0];
    wdata = {1'b0, nnt_pkg::coord_t'(in_data_i.x), nnt_pkg::coord_t'(in_data_i.y)};
    raddr = j_q;
    if (state_q == S_IDLE && in_valid_i && in_data_i.kind == nnt_pkg::KIND_LOAD &&
        placed_q == '0 && cnt_q < nnt_pkg::CNT_W'(nnt_pkg::MAX_CITIES)) begin
      we = 1'b1;
    end
    if (state_q == S_FETCH) begin
      raddr = best_q;
    end
    if (state_q == S_LATCH) begin
      we    = 1'b1;
      waddr = best_q;
      wdata = {1'b1, rdata[nnt_pkg::WORD_W-2:0]};
    end

    pv = rd_v_q || state_q == S_CLOSE;
    if (state_q == S_CLOSE) begin
      ptag_in = '{idx: '0, skip: 1'b0, last: 1'b1};
      bx      = x0_q;
      by      = y0_q;
    end else begin
      ptag_in = '{idx: rd_idx_q, skip: rdata[nnt_pkg::WORD_W-1], last: rd_last_q};
      bx      = rdata[2*C-1:C];
      by      = rdata[C-1:0];
    end

    take     = pipe_v && !ptag.skip && (!found_q || pd < best_d_q);
    nbest    = take ? ptag.idx : best_q;
    nbest_d  = take ? pd : best_d_q;
    len_n    = nnt_pkg::sat_add(len_q, pd);
    scan_end = nnt_pkg::CNT_W'(j_q) == cnt_q - nnt_pkg::CNT_W'(1);
    out_load = state_q == S_EMIT && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      placed_q    <= '0;
      cur_q       <= '0;
      len_q       <= '0;
      j_q         <= '0;
      best_q      <= '0;
      best_d_q    <= '0;
      found_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_idx_q    <= '0;
      curx_q      <= '0;
      cury_q      <= '0;
      x0_q        <= '0;
      y0_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q    <= state_q == S_SCAN;
      rd_last_q <= scan_end;
      rd_idx_q  <= j_q;
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (pipe_v && (state_q == S_SCAN || state_q == S_DRAIN)) begin
        best_q   <= nbest;
        best_d_q <= nbest_d;
        found_q  <= found_q || take;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.kind)
              nnt_pkg::KIND_LOAD: begin
                if (placed_q == '0 && cnt_q < nnt_pkg::CNT_W'(nnt_pkg::MAX_CITIES)) begin
                  cnt_q <= cnt_q + nnt_pkg::CNT_W'(1);
                  if (cnt_q == '0) begin
                    x0_q <= nnt_pkg::coord_t'(in_data_i.x);
                    y0_q <= nnt_pkg::coord_t'(in_data_i.y);
                  end
                end
              end
              nnt_pkg::KIND_CLEAR: begin
                cnt_q    <= '0;
                placed_q <= '0;
                cur_q    <= '0;
                len_q    <= '0;
              end
              nnt_pkg::KIND_ADVANCE: begin
                if (cnt_q == '0) begin
                  res_q   <= '{city: '0, running_length: '0, last_city: 1'b0,
                               status: nnt_pkg::STATUS_EMPTY};
                  state_q <= S_EMIT;
                end else if (placed_q >= cnt_q) begin
                  res_q   <= '{city: '0, running_length: len_q, last_city: 1'b0,
                               status: nnt_pkg::STATUS_DONE};
                  state_q <= S_EMIT;
                end else if (placed_q == '0) begin
                  best_q  <= '0;
                  state_q <= S_FETCH;
                end else begin
                  j_q     <= '0;
                  found_q <= 1'b0;
                  state_q <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          j_q <= j_q + nnt_pkg::IDX_W'(1);
          if (scan_end) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pipe_v && ptag.last) begin
            len_q   <= nnt_pkg::sat_add(len_q, nbest_d);
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_LATCH;
        end
        S_LATCH: begin
          curx_q   <= rdata[2*C-1:C];
          cury_q   <= rdata[C-1:0];
          cur_q    <= best_q;
          placed_q <= placed_q + nnt_pkg::CNT_W'(1);
          if (placed_q + nnt_pkg::CNT_W'(1) == cnt_q) begin
            state_q <= S_CLOSE;
          end else begin
            res_q   <= '{city: nnt_pkg::CITY_W'(best_q), running_length: len_q,
                         last_city: 1'b0, status: nnt_pkg::STATUS_OK};
            state_q <= S_EMIT;
          end
        end
        S_CLOSE: begin
          state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (pipe_v) begin
            len_q   <= len_n;
            res_q   <= '{city: nnt_pkg::CITY_W'(cur_q), running_length: len_n,
                         last_city: 1'b1, status: nnt_pkg::STATUS_OK};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NNT_ASSERT(a_placed_le_cnt, placed_q <= cnt_q, "placed count exceeds city count")
  `NNT_ASSERT(a_pipe_window, !pipe_v || state_q == S_SCAN || state_q == S_DRAIN || state_q == S_CWAIT, "distance result outside a scan")
  `NNT_ASSERT_NEXT(a_last_done, out_load && res_q.last_city, placed_q == cnt_q, "last city emitted before tour complete")
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import nnt_pkg::*;

  class tour_scoreboard;
    coord_t      cx[MAX_CITIES];
    coord_t      cy[MAX_CITIES];
    bit          seen[MAX_CITIES];
    int unsigned n_cities;
    int unsigned n_placed;
    int unsigned here;
    longint unsigned tour_len;
    out_t        expected_q[$];
    int unsigned n_mismatch;

    function void clear_tour();
      foreach (seen[i]) seen[i] = 1'b0;
      n_cities = 0;
      n_placed = 0;
      here = 0;
      tour_len = 0;
    endfunction

    function longint unsigned rounded_dist(int unsigned a, int unsigned b);
      longint dx, dy;
      longint unsigned s, r, t;
      dx = longint'(cx[a]) - longint'(cx[b]);
      dy = longint'(cy[a]) - longint'(cy[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      s = dx * dx + dy * dy;
      r = 0;
      for (int bitpos = 20; bitpos >= 0; bitpos--) begin
        t = r | (64'd1 << bitpos);
        if (t * t <= s) r = t;
      end
      if (s > r * r + r) r++;
      return r;
    endfunction

    function void add_length(longint unsigned d);
      tour_len += d;
      if (tour_len > longint'(LEN_MAX)) tour_len = longint'(LEN_MAX);
    endfunction

    function void note(in_t t);
      out_t o;
      int unsigned pick;
      longint unsigned best, d;
      bit found;
      case (t.kind)
        KIND_LOAD: begin
          if (n_placed == 0 && n_cities < MAX_CITIES) begin
            cx[n_cities] = t.x;
            cy[n_cities] = t.y;
            n_cities++;
          end
        end
        KIND_CLEAR: clear_tour();
        KIND_ADVANCE: begin
          o = '0;
          if (n_cities == 0) begin
            o.status = STATUS_EMPTY;
          end else if (n_placed >= n_cities) begin
            o.status = STATUS_DONE;
            o.running_length = tour_len[LEN_W-1:0];
          end else begin
            pick = 0;
            if (n_placed != 0) begin
              found = 1'b0;
              best = 0;
              for (int unsigned j = 0; j < n_cities; j++) begin
                if (seen[j]) continue;
                d = rounded_dist(here, j);
                if (!found || d < best) begin
                  best = d;
                  pick = j;
                  found = 1'b1;
                end
              end
              add_length(best);
            end
            seen[pick] = 1'b1;
            here = pick;
            n_placed++;
            if (n_placed == n_cities) begin
              add_length(rounded_dist(here, 0));
              o.last_city = 1'b1;
            end
            o.city = here[CITY_W-1:0];
            o.running_length = tour_len[LEN_W-1:0];
            o.status = STATUS_OK;
          end
          expected_q.push_back(o);
        end
        default: ;
      endcase
    endfunction

    function void check(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.city !== want.city || got.running_length !== want.running_length ||
          got.last_city !== want.last_city || got.status !== want.status) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  tour_scoreboard sb;
  int unsigned burst_left;
  int unsigned rx_mode;
  bit          long_hold_go;
  int unsigned n_sent;
  longint unsigned cycles;

  nearest_neighbor_tour dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note(in_data_i);
      if (out_valid_o && out_ready_i) sb.check(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 64'd3_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall modes plus one long hold
  initial begin
    int unsigned left;
    out_ready_i = 1'b0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_ready_i <= 1'b0;
        repeat (3000) @(negedge clk_i);
      end
      if (left == 0) begin
        rx_mode = $urandom_range(0, 2);
        left = $urandom_range(50, 200);
      end
      left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(kind_e k, coord_t x, coord_t y);
    in_t t;
    t.kind = k;
    t.x = x;
    t.y = y;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(bit tight);
    if (tight) return coord_t'($urandom_range(0, 6)) - 3;
    return coord_t'($urandom_range(0, 65535));
  endfunction

  initial begin
    int unsigned n, adv;
    bit tight;
    sb = new();
    sb.clear_tour();
    sb.n_mismatch = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    burst_left = 0;
    long_hold_go = 1'b0;
    n_sent = 0;
    cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_LOAD, 16'sd32767, -16'sd32768);
    send(KIND_LOAD, -16'sd32768, 16'sd32767);
    send(KIND_LOAD, 16'sd0, 16'sd0);
    send(KIND_LOAD, -16'sd1, -16'sd1);
    send(KIND_LOAD, 16'sd1, 16'sd1);
    send(kind_e'(2'd3), 16'sd5, 16'sd5);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_LOAD, 16'sd7, 16'sd7);
    for (int i = 0; i < 4; i++) send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_CLEAR, -16'sd1, -16'sd1);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_LOAD, -16'sd32768, -16'sd32768);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_CLEAR, 16'sd0, 16'sd0);
    wait_drained();

    // fill the store past capacity, take a few steps, then clear
    for (int i = 0; i < MAX_CITIES + 2; i++)
      send(KIND_LOAD, rand_coord(1'b0), rand_coord(1'b0));
    for (int i = 0; i < 3; i++) send(KIND_ADVANCE, 16'sd0, 16'sd0);
    send(KIND_CLEAR, 16'sd0, 16'sd0);
    n_sent = 0;

    for (int round = 0; n_sent < 580; round++) begin
      tight = ($urandom_range(0, 2) == 0);
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);
      send(KIND_CLEAR, rand_coord(1'b0), rand_coord(1'b0));
      if ($urandom_range(0, 7) == 0) send(KIND_ADVANCE, 16'sd0, 16'sd0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0) send(kind_e'(2'd3), rand_coord(1'b0), rand_coord(1'b0));
        send(KIND_LOAD, rand_coord(tight), rand_coord(tight));
      end
      if (round == 4) long_hold_go = 1'b1;
      adv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
      for (int i = 0; i < adv; i++) begin
        if ($urandom_range(0, 11) == 0) send(KIND_LOAD, rand_coord(1'b0), rand_coord(1'b0));
        send(KIND_ADVANCE, rand_coord(1'b0), rand_coord(1'b0));
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
